[hw/rtl/bez_pkg.sv]
// shared types, widths and the interpolation function of the bezier evaluator
// used by every module of the block; no dependencies

package bez_pkg;

   localparam int CW       = 24;
   localparam int T_FRAC   = 16;
   localparam int TW       = T_FRAC + 1;
   localparam int VAL_W    = CW + 2;
   localparam int OUT_W    = 28;
   localparam int PROD_W   = VAL_W + 1 + TW + 1;
   localparam int NUM_REGS = 8;
   localparam int IDX_W    = $clog2(NUM_REGS);
   localparam int ADDR_W   = IDX_W + 2;
   localparam int DATA_W   = 32;

   localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC;

   typedef logic signed [CW-1:0]    coord_type;
   typedef coord_type [3:0]         quad_type;
   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic [TW-1:0]           t_type;
   typedef logic signed [OUT_W-1:0] out_type;

   typedef enum logic [1:0] {
      CMD_POINT   = 2'd0,
      CMD_TANGENT = 2'd1,
      CMD_NORMAL  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic  ld2;
      logic  ld3;
      logic  ld4;
      logic  deriv1;
      t_type t1;
      t_type t2;
      t_type t3;
   } bez_ctl_type;

   // a + floor((b - a) * t / 2^T_FRAC)
   function automatic val_type lerp(input val_type a, input val_type b, input t_type t);
      logic signed [VAL_W:0]    diff;
      logic signed [PROD_W-1:0] prod;
      diff = {b[VAL_W-1], b} - {a[VAL_W-1], a};
      prod = diff * $signed({1'b0, t});
      return a + val_type'(prod[T_FRAC+VAL_W-1:T_FRAC]);
   endfunction

endpackage

[hw/rtl/bez_csr.sv]
// control point registers behind the apb-style configuration port
// depends on bez_pkg

module bez_csr import bez_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output quad_type          px,
   output quad_type          py
);

   coord_type        regs_ff [NUM_REGS];
   logic [IDX_W-1:0] idx;
   logic             wr;

   assign idx    = paddr[ADDR_W-1:2];
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;
   assign prdata = DATA_W'({{(DATA_W-CW){1'b0}}, regs_ff[idx]});

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (wr) begin
         regs_ff[idx] <= pwdata[CW-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         px[i] = regs_ff[2*i];
         py[i] = regs_ff[2*i+1];
      end
   end

endmodule

[hw/rtl/bez_axis.sv]
// one coordinate lane: three registered levels of de casteljau interpolation
// depends on bez_pkg

module bez_axis import bez_pkg::*; (
   input  logic        clock,
   input  bez_ctl_type ctl,
   input  quad_type    p,
   output val_type     lvl3
);

   val_type l1_ff [3];
   val_type l1_in [3];
   val_type l2_ff [2];
   val_type l2_in [2];
   val_type l3_ff;
   val_type l3_in;
   val_type pe    [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pe[i] = {{(VAL_W-CW){p[i][CW-1]}}, p[i]};
      end
      // derivative skips the first level and starts from the point differences
      for (int i = 0; i < 3; i++) begin
         if (ctl.deriv1) begin
            l1_in[i] = pe[i+1] - pe[i];
         end else begin
            l1_in[i] = lerp(pe[i], pe[i+1], ctl.t1);
         end
      end
      for (int i = 0; i < 2; i++) begin
         l2_in[i] = lerp(l1_ff[i], l1_ff[i+1], ctl.t2);
      end
      l3_in = lerp(l2_ff[0], l2_ff[1], ctl.t3);
   end

   always_ff @(posedge clock) begin
      if (ctl.ld2) begin
         l1_ff <= l1_in;
      end
      if (ctl.ld3) begin
         l2_ff <= l2_in;
      end
      if (ctl.ld4) begin
         l3_ff <= l3_in;
      end
   end

   assign lvl3 = l3_ff;

endmodule

[hw/rtl/cubic_bezier_2d_evaluator.sv]
// top level of the cubic bezier evaluator: handshake, control pipeline, output stage
// depends on bez_pkg, bez_csr and bez_axis

// Evaluates a 2D cubic Bezier curve whose four control points sit in eight
// configuration registers. Each request word carries t (Q1.16, values above 1.0
// act as 1.0) and a command: curve point, tangent, or tangent turned left or
// right. One word enters per clock cycle while req_stall is low. Its result
// passes an input register, three registered interpolation levels (three,
// two and one multipliers per axis) and the output register that scales,
// turns and presents the result. A stall on the result channel fills empty
// stages first and only then holds back requests.
// Control points must be written while no request is in flight.

module cubic_bezier_2d_evaluator import bez_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_command,
   input  logic [TW-1:0]     req_param_t,
   input  logic              req_turn_left,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [OUT_W-1:0]  rsp_result_x,
   output logic [OUT_W-1:0]  rsp_result_y,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   quad_type    px;
   quad_type    py;
   bez_ctl_type ctl;
   val_type     lvl_x;
   val_type     lvl_y;

   logic [5:1]  v_ff;
   logic [5:1]  v_in;
   logic [5:1]  rdy;
   cmd_type     cmd_ff  [1:4];
   logic        left_ff [1:4];
   t_type       t_ff    [1:3];
   t_type       t_in;
   out_type     rx_ff, rx_in;
   out_type     ry_ff, ry_in;
   out_type     ex, ey, tx, ty;

   bez_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .px      (px),
      .py      (py)
   );

   // stage readiness, from the output back to the input
   always_comb begin
      rdy[5] = ~v_ff[5] | ~rsp_stall;
      for (int k = 4; k >= 1; k--) begin
         rdy[k] = ~v_ff[k] | rdy[k+1];
      end
      v_in[1] = rdy[1] ? req_valid : v_ff[1];
      for (int k = 2; k <= 5; k++) begin
         v_in[k] = rdy[k] ? v_ff[k-1] : v_ff[k];
      end
      t_in = (req_param_t > T_ONE) ? T_ONE : req_param_t;
   end

   assign req_stall = ~rdy[1];

   always_comb begin
      ctl.ld2    = rdy[2];
      ctl.ld3    = rdy[3];
      ctl.ld4    = rdy[4];
      ctl.deriv1 = (cmd_ff[1] == CMD_TANGENT) || (cmd_ff[1] == CMD_NORMAL);
      ctl.t1     = t_ff[1];
      ctl.t2     = t_ff[2];
      ctl.t3     = t_ff[3];
   end

   bez_axis u_axis_x (
      .clock (clock),
      .ctl   (ctl),
      .p     (px),
      .lvl3  (lvl_x)
   );

   bez_axis u_axis_y (
      .clock (clock),
      .ctl   (ctl),
      .p     (py),
      .lvl3  (lvl_y)
   );

   always_comb begin
      ex = {{(OUT_W-VAL_W){lvl_x[VAL_W-1]}}, lvl_x};
      ey = {{(OUT_W-VAL_W){lvl_y[VAL_W-1]}}, lvl_y};
      tx = ex + (ex <<< 1);
      ty = ey + (ey <<< 1);
      case (cmd_ff[4])
         CMD_POINT: begin
            rx_in = ex;
            ry_in = ey;
         end
         CMD_TANGENT: begin
            rx_in = tx;
            ry_in = ty;
         end
         CMD_NORMAL: begin
            if (left_ff[4]) begin
               rx_in = -ty;
               ry_in = tx;
            end else begin
               rx_in = ty;
               ry_in = -tx;
            end
         end
         default: begin
            rx_in = '0;
            ry_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         cmd_ff[1]  <= cmd_type'(req_command);
         left_ff[1] <= req_turn_left;
         t_ff[1]    <= t_in;
      end
      for (int k = 2; k <= 4; k++) begin
         if (rdy[k]) begin
            cmd_ff[k]  <= cmd_ff[k-1];
            left_ff[k] <= left_ff[k-1];
         end
      end
      for (int k = 2; k <= 3; k++) begin
         if (rdy[k]) begin
            t_ff[k] <= t_ff[k-1];
         end
      end
      if (rdy[5]) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
      end
   end

   assign rsp_valid    = v_ff[5];
   assign rsp_result_x = rx_ff;
   assign rsp_result_y = ry_ff;

endmodule

[hw/rtl/bez_chk.sv]
// port-level checks on the bezier evaluator, bound to the top level
// depends on bez_pkg and cubic_bezier_2d_evaluator

module bez_chk import bez_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [OUT_W-1:0]  rsp_result_x,
   input logic [OUT_W-1:0]  rsp_result_y,
   input logic              csr_pready
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_x) && $stable(rsp_result_y))
      else $error("stalled result word changed");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("configuration port not ready");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while the result side is free");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_stall) ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("result word missing five cycles after acceptance");

endmodule

bind cubic_bezier_2d_evaluator bez_chk u_chk (.*);
